// ----- rtl/core/hvt_pkg.sv -----
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared widths, constants and types of the vertex transform pipeline.
// ----------------------------------------------------------------------------
package hvt_pkg;

   localparam int DATA_W     = 32;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int QUO_W      = 33;
   localparam int DIV_STAGES = QUO_W;

   localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

   typedef logic [3:0][DATA_W-1:0]  vec4_type;
   typedef logic [15:0][DATA_W-1:0] mat_type;

   typedef enum logic [1:0] {
      CLS_PASS,
      CLS_ZERO,
      CLS_DIV
   } cls_type;

   typedef struct packed {
      cls_type  cls;
      vec4_type raw;
   } side_type;

endpackage

// ----- rtl/core/homogeneous_vertex_transform_top.sv -----
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_top
// 4x4 fixed-point matrix by vector transform with perspective divide.
//
//   channel  dir  beat content
//   req_     in   tdata: vec_x, vec_y, vec_z, vec_w
//   rsp_     out  tdata: out_x, out_y, out_z, out_w; tuser: w_zero
//   csr_     in   index 0..7 selects one 64-bit matrix register
//
// One beat per cycle: product and row sum stages, a divide setup register,
// the bit-per-stage dividers with their rounding stage, an output register.
// Reset clears the valid bits and loads the identity matrix.
// The pipeline holds as a whole while a result waits at the output.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata,  // vec_x, vec_y, vec_z, vec_w
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [127:0]                    rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic                            rsp_tuser,  // w_zero
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hvt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                     csr_data
);

   localparam int               NUM_W = 32 + FRAC_BITS;
   localparam int               DS    = hvt_pkg::DIV_STAGES;
   localparam int               LAT   = DS + 6;
   localparam logic [31:0]      ONE   = 32'd1 << FRAC_BITS;

   logic [63:0]          mat_ff [hvt_pkg::NUM_REGS];
   logic [LAT-1:0]       vld_ff;
   logic                 en;
   hvt_pkg::mat_type     mat;
   hvt_pkg::vec4_type    res;
   logic [NUM_W-1:0]     num_ff [3];
   logic [31:0]          den_ff [3];
   logic                 neg_ff [3];
   logic                 ovf_ff [3];
   logic [31:0]          quo    [3];
   hvt_pkg::side_type    side_ff [DS+2];
   hvt_pkg::side_type    side_in;
   logic [127:0]         rsp_tdata_ff;
   logic [127:0]         rsp_tdata_in;
   logic                 rsp_tuser_ff;
   logic                 rsp_tuser_in;

   assign csr_ready  = 1'b1;
   assign en         = ~(vld_ff[LAT-1] & ~rsp_tready);
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= {32'd0, ONE};
         mat_ff[1] <= '0;
         mat_ff[2] <= {ONE, 32'd0};
         mat_ff[3] <= '0;
         mat_ff[4] <= '0;
         mat_ff[5] <= {32'd0, ONE};
         mat_ff[6] <= '0;
         mat_ff[7] <= {ONE, 32'd0};
      end else if (csr_valid && csr_index < hvt_pkg::CSR_IDX_W'(hvt_pkg::NUM_REGS)) begin
         mat_ff[csr_index[2:0]] <= csr_data;
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_mat
      assign mat[4*r+0] = mat_ff[2*r][31:0];
      assign mat[4*r+1] = mat_ff[2*r][63:32];
      assign mat[4*r+2] = mat_ff[2*r+1][31:0];
      assign mat[4*r+3] = mat_ff[2*r+1][63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   hvt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clock (clock),
      .en    (en),
      .vec   (req_tdata),
      .mat   (mat),
      .res   (res)
   );

   logic [31:0] den_abs;
   assign den_abs = res[3][31] ? 32'(-res[3]) : res[3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [31:0]      num_abs;
      logic [NUM_W-1:0] num_in;

      assign num_abs = res[i][31] ? 32'(-res[i]) : res[i];
      assign num_in  = {num_abs, {FRAC_BITS{1'b0}}};

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= num_in;
            den_ff[i] <= den_abs;
            neg_ff[i] <= res[i][31] ^ res[3][31];
            ovf_ff[i] <= (num_in >> hvt_pkg::QUO_W) >= NUM_W'(den_abs);
         end
      end

      hvt_div #(.NUM_W(NUM_W)) u_div (
         .clock   (clock),
         .en      (en),
         .num_in  (num_ff[i]),
         .den_in  (den_ff[i]),
         .neg_in  (neg_ff[i]),
         .ovf_in  (ovf_ff[i]),
         .res_out (quo[i])
      );
   end

   always_comb begin
      side_in.raw = res;
      if (res[3] == ONE) begin
         side_in.cls = hvt_pkg::CLS_PASS;
      end else if (res[3] == '0) begin
         side_in.cls = hvt_pkg::CLS_ZERO;
      end else begin
         side_in.cls = hvt_pkg::CLS_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < DS + 2; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      rsp_tuser_in = 1'b0;
      case (side_ff[DS+1].cls)
         hvt_pkg::CLS_PASS: begin
            rsp_tdata_in = side_ff[DS+1].raw;
         end
         hvt_pkg::CLS_ZERO: begin
            rsp_tdata_in = {4{hvt_pkg::WORD_MAX}};
            rsp_tuser_in = 1'b1;
         end
         hvt_pkg::CLS_DIV: begin
            rsp_tdata_in = {ONE, quo[2], quo[1], quo[0]};
         end
         default: begin
            rsp_tdata_in = side_ff[DS+1].raw;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_zero_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == {4{hvt_pkg::WORD_MAX}})
      else $error("w zero result not saturated");

   a_div_w_one : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[127:96] != 32'd0)
      else $error("zero w delivered without flag");

   a_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held without output stall");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

// ----- rtl/core/hvt_dot.sv -----
// ----------------------------------------------------------------------------
// hvt_dot
// Matrix by vector product: products, pair sums, then row sum with rounding
// and saturation. Three register stages.
// ----------------------------------------------------------------------------
module hvt_dot #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              en,
   input  hvt_pkg::vec4_type vec,
   input  hvt_pkg::mat_type  mat,
   output hvt_pkg::vec4_type res
);

   localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   logic signed [63:0] prod_ff [16];
   logic signed [64:0] pair_ff [8];
   hvt_pkg::vec4_type  res_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 16; i++) begin
            prod_ff[i] <= $signed(mat[i]) * $signed(vec[i % 4]);
         end
         for (int j = 0; j < 8; j++) begin
            pair_ff[j] <= $signed({prod_ff[2*j][63], prod_ff[2*j]})
                        + $signed({prod_ff[2*j+1][63], prod_ff[2*j+1]});
         end
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_row
      logic signed [65:0] tot_in;
      logic signed [65:0] sh_in;
      logic [31:0]        sat_in;

      always_comb begin
         tot_in = $signed({pair_ff[2*r][64], pair_ff[2*r]})
                + $signed({pair_ff[2*r+1][64], pair_ff[2*r+1]}) + HALF;
         sh_in  = tot_in >>> FRAC_BITS;
         if (sh_in > SAT_HI) begin
            sat_in = hvt_pkg::WORD_MAX;
         end else if (sh_in < SAT_LO) begin
            sat_in = hvt_pkg::WORD_MIN;
         end else begin
            sat_in = sh_in[31:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[r] <= sat_in;
         end
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/hvt_div.sv -----
// ----------------------------------------------------------------------------
// hvt_div
// Pipelined restoring divider lane, one quotient bit per stage, followed by
// a round to nearest and a signed saturation stage.
// ----------------------------------------------------------------------------
module hvt_div #(
   parameter int NUM_W = 48
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [31:0]      den_in,
   input  logic             neg_in,
   input  logic             ovf_in,
   output logic [31:0]      res_out
);

   localparam int QW = hvt_pkg::QUO_W;
   localparam int DS = hvt_pkg::DIV_STAGES;

   logic [31:0]   rem_ff [DS];
   logic [QW-1:0] quo_ff [DS];
   logic [QW-1:0] num_ff [DS];
   logic [31:0]   den_ff [DS];
   logic          neg_ff [DS];
   logic          ovf_ff [DS];
   logic [31:0]   res_ff;

   for (genvar k = 0; k < DS; k++) begin : g_stage
      logic [31:0]   rem_prev;
      logic [QW-1:0] quo_prev;
      logic [QW-1:0] num_prev;
      logic [31:0]   den_prev;
      logic          neg_prev;
      logic          ovf_prev;
      logic [32:0]   rem2;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_prev = 32'(num_in >> QW);
         assign quo_prev = '0;
         assign num_prev = num_in[QW-1:0];
         assign den_prev = den_in;
         assign neg_prev = neg_in;
         assign ovf_prev = ovf_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign neg_prev = neg_ff[k-1];
         assign ovf_prev = ovf_ff[k-1];
      end

      assign rem2 = {rem_prev, num_prev[QW-1-k]};
      assign ge   = rem2 >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? 32'(rem2 - {1'b0, den_prev}) : rem2[31:0];
            quo_ff[k] <= {quo_prev[QW-2:0], ge};
            num_ff[k] <= num_prev;
            den_ff[k] <= den_prev;
            neg_ff[k] <= neg_prev;
            ovf_ff[k] <= ovf_prev;
         end
      end
   end

   logic        rnd;
   logic [33:0] qr;
   logic [31:0] res_in;

   always_comb begin
      rnd = {rem_ff[DS-1], 1'b0} >= {1'b0, den_ff[DS-1]};
      qr  = {1'b0, quo_ff[DS-1]} + {33'd0, rnd};
      if (ovf_ff[DS-1]) begin
         res_in = neg_ff[DS-1] ? hvt_pkg::WORD_MIN : hvt_pkg::WORD_MAX;
      end else if (neg_ff[DS-1]) begin
         res_in = (qr > 34'h0_8000_0000) ? hvt_pkg::WORD_MIN : 32'(-qr);
      end else begin
         res_in = (qr > 34'h0_7FFF_FFFF) ? hvt_pkg::WORD_MAX : qr[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res_out = res_ff;

endmodule

// ----- tb/tb_homogeneous_vertex_transform_top.sv -----
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform_top
// Self-checking bench for the 4x4 matrix transform with perspective divide.
// A directed table runs on the identity matrix after reset. Several matrix
// settings follow, random or at the word limits, each with random vertices.
// Sender gaps and receiver stalls vary from phase to phase. Every result beat
// is checked against the table's value or a software model of the transform.
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform_top;

   localparam int FRAC      = 16;
   localparam int ONE       = 1 << FRAC;
   localparam int LATENCY   = 45;
   localparam int WD_LIMIT  = 4000;
   localparam int NUM_PHASE = 8;

   typedef struct packed {
      logic [127:0] data;
      logic         flag;
   } vertex_out_type;

   typedef struct {
      logic [127:0] vec;
      bit           typed;
      logic [127:0] exp_data;
      logic         exp_flag;
   } vec_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [hvt_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]  csr_data = '0;

   logic [63:0]    matrix_regs [hvt_pkg::NUM_REGS];
   vertex_out_type pending_vertices [$];
   int           errors = 0;
   int           sent = 0;
   int           checked = 0;
   int           zero_w_seen = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_cycles = 0;
   int           quiet_cycles = 0;

   homogeneous_vertex_transform_top uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   function automatic logic signed [31:0] sat_word(logic signed [67:0] v);
      if (v > 68'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -68'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] row_dot(int r, logic [127:0] vec);
      logic signed [67:0] acc;
      logic signed [31:0] m;
      logic signed [31:0] vv;
      logic signed [63:0] p;
      acc = '0;
      for (int c = 0; c < 4; c++) begin
         m   = matrix_regs[2 * r + c / 2][32 * (c % 2) +: 32];
         vv  = vec[32 * c +: 32];
         p   = m * vv;
         acc = acc + p;
      end
      acc = (acc + 68'sd32768) >>> FRAC;
      return sat_word(acc);
   endfunction

   function automatic logic signed [31:0] fx_divide(logic signed [31:0] num,
                                                    logic signed [31:0] den);
      longint          sn;
      longint          sd;
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      bit              neg;
      sn  = num;
      sd  = den;
      neg = (sn < 0) != (sd < 0);
      n   = longint'(sn < 0 ? -sn : sn) << FRAC;
      d   = sd < 0 ? -sd : sd;
      q   = (2 * n + d) / (2 * d);
      if (neg) begin
         if (q > 64'd2147483648) return 32'sh8000_0000;
         return 32'(-q);
      end
      if (q > 64'd2147483647) return 32'sh7FFF_FFFF;
      return q[31:0];
   endfunction

   function automatic vertex_out_type transform_vertex(logic [127:0] vec);
      logic signed [31:0] r [4];
      vertex_out_type     o;
      for (int i = 0; i < 4; i++) r[i] = row_dot(i, vec);
      o.flag = 1'b0;
      if (r[3] == 0) begin
         for (int i = 0; i < 4; i++) r[i] = hvt_pkg::WORD_MAX;
         o.flag = 1'b1;
      end else if (r[3] != ONE) begin
         for (int i = 0; i < 3; i++) r[i] = fx_divide(r[i], r[3]);
         r[3] = ONE;
      end
      o.data = {r[3], r[2], r[1], r[0]};
      return o;
   endfunction

   task automatic report(string what, logic [127:0] got, logic [127:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   // result checker and watchdog
   always @(negedge clock) begin
      vertex_out_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (pending_vertices.size() == 0) begin
               report("unexpected beat", rsp_tdata, '0);
            end else begin
               want = pending_vertices.pop_front();
               if (want.flag) zero_w_seen++;
               for (int i = 0; i < 4; i++)
                  if (rsp_tdata[32 * i +: 32] !== want.data[32 * i +: 32])
                     report($sformatf("component %0d", i), 128'(rsp_tdata[32 * i +: 32]),
                            128'(want.data[32 * i +: 32]));
               if (rsp_tuser !== want.flag)
                  report("w_zero", 128'(rsp_tuser), 128'(want.flag));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog expired, %0d beats outstanding", pending_vertices.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // receiver with random stalls and a long hold-off on request
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_vertex(logic [127:0] vec, bit typed, vertex_out_type typed_out);
      bit acc;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= vec;
      do begin
         @(negedge clock);
         acc = req_tready;
         @(posedge clock);
      end while (!acc);
      pending_vertices.push_back(typed ? typed_out : transform_vertex(vec));
      sent++;
   endtask

   task automatic write_reg(logic [hvt_pkg::CSR_IDX_W-1:0] idx, logic [63:0] value);
      bit acc;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         acc = csr_ready;
         @(posedge clock);
      end while (!acc);
      if (idx < hvt_pkg::NUM_REGS) matrix_regs[idx[2:0]] = value;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic [31:0] small_fx();
      return $unsigned(int'($urandom_range(0, 1 << 19)) - (1 << 18));
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(4))
         0: return $urandom;
         1: return ONE;
         2: return '0;
         default: return small_fx();
      endcase
   endfunction

   function automatic logic [63:0] matrix_word(int kind, int idx);
      case (kind)
         1: return (idx == 7) ? {32'(ONE), 32'd0} : {small_fx(), small_fx()};
         3: return {hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX};
         4: return {hvt_pkg::WORD_MIN, hvt_pkg::WORD_MIN};
         5: return (idx >= 6) ? 64'd0 : {small_fx(), small_fx()};
         6: return {$urandom, $urandom};
         default: return (idx == 6) ? {32'd0, 32'd0} : {small_fx(), small_fx()};
      endcase
   endfunction

   vec_row_type    dir_rows [$];
   vertex_out_type typed_out;
   logic [127:0]   vec;

   initial begin
      for (int i = 0; i < hvt_pkg::NUM_REGS; i++) matrix_regs[i] = '0;
      matrix_regs[0] = 64'(ONE);
      matrix_regs[2] = 64'(ONE) << 32;
      matrix_regs[5] = 64'(ONE);
      matrix_regs[7] = 64'(ONE) << 32;

      dir_rows = '{
         '{{32'(ONE), 32'h7FFF_FFFF, 32'h0, 32'h8000_0000}, 1,
           {32'(ONE), 32'h7FFF_FFFF, 32'h0, 32'h8000_0000}, 1'b0},
         '{{32'(ONE), 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001}, 1,
           {32'(ONE), 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001}, 1'b0},
         '{{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1}, 1,
           {hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX},
           1'b1},
         '{{32'h0, 32'h0, 32'h0, 32'h0}, 1,
           {hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX, hvt_pkg::WORD_MAX},
           1'b1},
         '{{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1}, 0, '0, 1'b0},
         '{{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}, 0, '0, 1'b0},
         '{{32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678}, 0, '0, 1'b0},
         '{{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 0, '0, 1'b0},
         '{{32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0001}, 0, '0, 1'b0},
         '{{32'h0002_0000, 32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_8000}, 0, '0, 1'b0},
         '{{32'h0003_0000, 32'h0001_0000, 32'h0000_0001, 32'h0000_0003}, 0, '0, 1'b0},
         '{{32'h0001_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002}, 0, '0, 1'b0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         typed_out.data = dir_rows[i].exp_data;
         typed_out.flag = dir_rows[i].exp_flag;
         send_vertex(dir_rows[i].vec, dir_rows[i].typed, typed_out);
      end
      drain();

      for (int p = 0; p < NUM_PHASE; p++) begin
         if (p != 0) begin
            for (int r = 0; r < hvt_pkg::NUM_REGS; r++)
               write_reg(hvt_pkg::CSR_IDX_W'(r), matrix_word(p, r));
            write_reg(hvt_pkg::CSR_IDX_W'(hvt_pkg::NUM_REGS +
                                           $urandom_range(hvt_pkg::NUM_REGS - 1)),
                      {$urandom, $urandom});
            csr_valid <= 1'b0;
         end
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         if (p == 4) hold_cycles = 300;
         for (int k = 0; k < 175; k++) begin
            vec = {random_word(), random_word(), random_word(), random_word()};
            if ($urandom_range(3) == 0) vec = {$urandom, $urandom, $urandom, $urandom};
            send_vertex(vec, 0, typed_out);
         end
         drain();
      end
      send_idle_pct = 0;
      stall_pct = 0;

      $display("%0d vertices sent, %0d results checked, %0d with zero w", sent, checked,
               zero_w_seen);
      $display("%0d matrix settings with varied sender gaps and receiver stalls", NUM_PHASE);
      if (errors == 0 && pending_vertices.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
